>>> hdl/sicm_pkg.sv
// Shared constants, types and helpers for the staggered isometric coordinate map.
`default_nettype none
package sicm_pkg;

  localparam int SCR_W     = 24;                  // signed Q16.8 screen values
  localparam int IDX_W     = 16;                  // signed cell indexes
  localparam int ZOOM_W    = 16;                  // unsigned Q8.8 zoom
  localparam int CELL_W    = 23;                  // unsigned Q15.8 cell size
  localparam int ZOOM_FRAC = 8;
  localparam int NORM_FRAC = 16;                  // fraction bits of the normalized point
  localparam int DIV_W     = ZOOM_W + CELL_W;     // divisor zoom * cell size
  localparam int REM_W     = DIV_W + 1;
  localparam int NUM_W     = 52;                  // numerator, padded to whole steps
  localparam int BPS       = 4;                   // quotient bits per divider stage
  localparam int DSTEPS    = NUM_W / BPS;
  localparam int NX_W      = NUM_W + 1;
  localparam int NST       = DSTEPS + 4;          // valid stages, output stage last
  localparam int ADDR_W    = 5;

  typedef enum logic [2:0] {
    REG_CAMERA_X    = 3'd0,
    REG_CAMERA_Y    = 3'd1,
    REG_ZOOM        = 3'd2,
    REG_CELL_WIDTH  = 3'd3,
    REG_CELL_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic {
    FUNC_PICK  = 1'b0,
    FUNC_PLACE = 1'b1
  } func_t;

  // Partial state of one restoring division
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] q;
  } divs_t;

  // One divider pipeline stage, with the place result riding along
  typedef struct packed {
    logic              func;
    logic              zd;
    logic              neg_x;
    logic              neg_y;
    logic [DIV_W-1:0]  dv_x;
    logic [DIV_W-1:0]  dv_y;
    divs_t             x;
    divs_t             y;
    logic [SCR_W-1:0]  sx;
    logic [SCR_W-1:0]  sy;
  } dstage_t;

  // Retire BPS quotient bits of a restoring division
  function automatic divs_t div_step(input divs_t s, input logic [DIV_W-1:0] d);
    logic [REM_W-1:0] t;
    divs_t            o;
    o = s;
    for (int i = 0; i < BPS; i++) begin
      t     = {o.rem, o.num[NUM_W-1]};
      o.num = {o.num[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t   = t - {1'b0, d};
        o.q = {o.q[NUM_W-2:0], 1'b1};
      end else begin
        o.q = {o.q[NUM_W-2:0], 1'b0};
      end
      o.rem = t[DIV_W-1:0];
    end
    return o;
  endfunction

  // Saturate a wide signed value to the screen range
  function automatic logic [SCR_W-1:0] sat_scr(input logic signed [NX_W-1:0] v);
    logic signed [NX_W-1:0] hi;
    logic signed [NX_W-1:0] lo;
    hi = NX_W'(( 64'sd1 <<< (SCR_W - 1)) - 64'sd1);
    lo = -hi - NX_W'(1);
    if (v > hi) begin
      return hi[SCR_W-1:0];
    end else if (v < lo) begin
      return lo[SCR_W-1:0];
    end
    return v[SCR_W-1:0];
  endfunction

  // Saturate a wide signed value to the cell index range
  function automatic logic [IDX_W-1:0] sat_idx(input logic signed [NX_W-1:0] v);
    logic signed [NX_W-1:0] hi;
    logic signed [NX_W-1:0] lo;
    hi = NX_W'((64'sd1 <<< (IDX_W - 1)) - 64'sd1);
    lo = -hi - NX_W'(1);
    if (v > hi) begin
      return hi[IDX_W-1:0];
    end else if (v < lo) begin
      return lo[IDX_W-1:0];
    end
    return v[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/sicm_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface sicm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [sicm_pkg::SCR_W-1:0]   point_x;
  logic signed [sicm_pkg::SCR_W-1:0]   point_y;
  logic signed [sicm_pkg::IDX_W-1:0]   column_in;
  logic signed [sicm_pkg::IDX_W-1:0]   row_in;
  modport source (output valid, func, point_x, point_y, column_in, row_in, input ready);
  modport sink (input valid, func, point_x, point_y, column_in, row_in, output ready);
endinterface

interface sicm_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [sicm_pkg::IDX_W-1:0]   column_out;
  logic signed [sicm_pkg::IDX_W-1:0]   row_out;
  logic signed [sicm_pkg::SCR_W-1:0]   screen_x;
  logic signed [sicm_pkg::SCR_W-1:0]   screen_y;
  modport source (output valid, hit, column_out, row_out, screen_x, screen_y, input ready);
  modport sink (input valid, hit, column_out, row_out, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

>>> hdl/staggered_iso_coordinate_map_core.sv
// Pipelined pick/place converter between screen points and staggered iso map cells.
//
//  channel  | kind         | content
//  in_if    | valid/ready  | func, point_x, point_y, column_in, row_in
//  out_if   | valid/ready  | hit, column_out, row_out, screen_x, screen_y
//  cfg_*    | APB write/rd | camera_x, camera_y, zoom, cell_width, cell_height
//
// One transfer per cycle in each direction while out_if.ready is held high.
// The depth is set by the restoring dividers: 13 stages of 4 quotient bits each,
// after a multiply stage and a numerator stage, followed by a sign fix and diamond stage.
// Each stage holds when its successor is full and stalled; bubbles close up.
// rst_n (synchronous) empties the pipeline and loads the register defaults.
`default_nettype none
module staggered_iso_coordinate_map_core (
  input  wire                          clk,
  input  wire                          rst_n,
  sicm_in_if.sink                      in_if,
  sicm_out_if.source                   out_if,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [sicm_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire [31:0]                   cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int OUT_ST = sicm_pkg::NST - 1;
  localparam int SCR_W  = sicm_pkg::SCR_W;
  localparam int IDX_W  = sicm_pkg::IDX_W;
  localparam int DIV_W  = sicm_pkg::DIV_W;
  localparam int NUM_W  = sicm_pkg::NUM_W;
  localparam int NX_W   = sicm_pkg::NX_W;

  // Configuration registers
  logic signed [SCR_W-1:0]            camx_r;
  logic signed [SCR_W-1:0]            camy_r;
  logic [sicm_pkg::ZOOM_W-1:0]        zoom_r;
  logic [sicm_pkg::CELL_W-1:0]        cw_r;
  logic [sicm_pkg::CELL_W-1:0]        ch_r;
  sicm_pkg::reg_idx_t                 cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = sicm_pkg::reg_idx_t'(cfg_paddr[4:2]);

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camx_r <= '0;
      camy_r <= '0;
      zoom_r <= sicm_pkg::ZOOM_W'(256);
      cw_r   <= sicm_pkg::CELL_W'(16384);
      ch_r   <= sicm_pkg::CELL_W'(8192);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        sicm_pkg::REG_CAMERA_X:    camx_r <= cfg_pwdata[SCR_W-1:0];
        sicm_pkg::REG_CAMERA_Y:    camy_r <= cfg_pwdata[SCR_W-1:0];
        sicm_pkg::REG_ZOOM:        zoom_r <= cfg_pwdata[sicm_pkg::ZOOM_W-1:0];
        sicm_pkg::REG_CELL_WIDTH:  cw_r   <= cfg_pwdata[sicm_pkg::CELL_W-1:0];
        sicm_pkg::REG_CELL_HEIGHT: ch_r   <= cfg_pwdata[sicm_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      sicm_pkg::REG_CAMERA_X:    cfg_prdata = 32'({8'd0, camx_r});
      sicm_pkg::REG_CAMERA_Y:    cfg_prdata = 32'({8'd0, camy_r});
      sicm_pkg::REG_ZOOM:        cfg_prdata = 32'(zoom_r);
      sicm_pkg::REG_CELL_WIDTH:  cfg_prdata = 32'(cw_r);
      sicm_pkg::REG_CELL_HEIGHT: cfg_prdata = 32'(ch_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Stage valids and load enables
  logic [sicm_pkg::NST-1:0] v_r;
  logic [sicm_pkg::NST-1:0] en;

  always_comb begin
    en[OUT_ST] = !v_r[OUT_ST] || out_if.ready;
    for (int i = OUT_ST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_if.valid;
      end
      for (int i = 1; i < sicm_pkg::NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 0: camera offset, divisors, first place products
  logic                     s0_func_r;
  logic [DIV_W-1:0]         s0_dvx_r, s0_dvy_r;
  logic signed [SCR_W:0]    s0_ax_r, s0_ay_r;
  logic signed [41:0]       s0_mx_r;
  logic signed [40:0]       s0_my_r;
  logic signed [17:0]       tx;
  logic signed [16:0]       ty;

  always_comb begin
    tx = ({{2{in_if.column_in[IDX_W-1]}}, in_if.column_in} <<< 1) + 18'sd1
         + $signed({17'd0, in_if.row_in[0]});
    ty = {in_if.row_in[IDX_W-1], in_if.row_in} + 17'sd1;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_func_r <= in_if.func;
      s0_dvx_r  <= DIV_W'(zoom_r) * DIV_W'(cw_r);
      s0_dvy_r  <= DIV_W'(zoom_r) * DIV_W'(ch_r);
      s0_ax_r   <= {in_if.point_x[SCR_W-1], in_if.point_x} - {camx_r[SCR_W-1], camx_r};
      s0_ay_r   <= {in_if.point_y[SCR_W-1], in_if.point_y} - {camy_r[SCR_W-1], camy_r};
      s0_mx_r   <= 42'(tx) * 42'($signed({1'b0, cw_r}));
      s0_my_r   <= 41'(ty) * 41'($signed({1'b0, ch_r}));
    end
  end

  // Stage 1: numerator magnitudes, zoom product for place
  logic                     s1_func_r, s1_zd_r, s1_negx_r, s1_negy_r;
  logic [DIV_W-1:0]         s1_dvx_r, s1_dvy_r;
  logic [NUM_W-1:0]         s1_numx_r, s1_numy_r;
  logic signed [58:0]       s1_px_r, s1_py_r;
  logic [SCR_W:0]           magx, magy;

  always_comb begin
    magx = s0_ax_r[SCR_W] ? 25'(-s0_ax_r) : s0_ax_r;
    magy = s0_ay_r[SCR_W] ? 25'(-s0_ay_r) : s0_ay_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_func_r <= s0_func_r;
      s1_zd_r   <= (s0_dvx_r == '0) || (s0_dvy_r == '0);
      s1_negx_r <= s0_ax_r[SCR_W];
      s1_negy_r <= s0_ay_r[SCR_W];
      s1_dvx_r  <= s0_dvx_r;
      s1_dvy_r  <= s0_dvy_r;
      s1_numx_r <= NUM_W'({magx, 24'd0});
      s1_numy_r <= NUM_W'({magy, 24'd0});
      s1_px_r   <= 59'(s0_mx_r) * 59'($signed({1'b0, zoom_r}));
      s1_py_r   <= 59'(s0_my_r) * 59'($signed({1'b0, zoom_r}));
    end
  end

  // Divider stages; the place result is finished entering the first one
  sicm_pkg::dstage_t dv_r [sicm_pkg::DSTEPS];
  sicm_pkg::dstage_t dv_in [sicm_pkg::DSTEPS];
  sicm_pkg::dstage_t d_head;
  logic signed [NX_W-1:0] plx, ply;

  always_comb begin
    plx = NX_W'((60'(s1_px_r) + 60'sd256) >>> 9) + NX_W'(camx_r);
    ply = NX_W'((60'(s1_py_r) + 60'sd256) >>> 9) + NX_W'(camy_r);
    d_head.func  = s1_func_r;
    d_head.zd    = s1_zd_r;
    d_head.neg_x = s1_negx_r;
    d_head.neg_y = s1_negy_r;
    d_head.dv_x  = s1_dvx_r;
    d_head.dv_y  = s1_dvy_r;
    d_head.x     = '{rem: '0, num: s1_numx_r, q: '0};
    d_head.y     = '{rem: '0, num: s1_numy_r, q: '0};
    d_head.sx    = sicm_pkg::sat_scr(plx);
    d_head.sy    = sicm_pkg::sat_scr(ply);
    for (int k = 0; k < sicm_pkg::DSTEPS; k++) begin
      dv_in[k]   = (k == 0) ? d_head : dv_r[(k == 0) ? 0 : k - 1];
      dv_in[k].x = sicm_pkg::div_step(dv_in[k].x, dv_in[k].dv_x);
      dv_in[k].y = sicm_pkg::div_step(dv_in[k].y, dv_in[k].dv_y);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < sicm_pkg::DSTEPS; k++) begin
      if (en[k+2]) begin
        dv_r[k] <= dv_in[k];
      end
    end
  end

  // Post stage: floor the signed quotients
  localparam int LAST = sicm_pkg::DSTEPS - 1;
  logic                     p_func_r, p_zd_r;
  logic signed [NX_W-1:0]   p_nx_r, p_ny_r;
  logic [SCR_W-1:0]         p_sx_r, p_sy_r;
  logic signed [NX_W-1:0]   qx, qy;

  always_comb begin
    qx = $signed({1'b0, dv_r[LAST].x.q});
    qy = $signed({1'b0, dv_r[LAST].y.q});
  end

  always_ff @(posedge clk) begin
    if (en[sicm_pkg::DSTEPS+2]) begin
      p_func_r <= dv_r[LAST].func;
      p_zd_r   <= dv_r[LAST].zd;
      p_nx_r   <= dv_r[LAST].neg_x ?
                  -(qx + NX_W'(dv_r[LAST].x.rem != '0)) : qx;
      p_ny_r   <= dv_r[LAST].neg_y ?
                  -(qy + NX_W'(dv_r[LAST].y.rem != '0)) : qy;
      p_sx_r   <= dv_r[LAST].sx;
      p_sy_r   <= dv_r[LAST].sy;
    end
  end

  // Output stage: diamond tests against both grids
  localparam logic signed [NX_W-1:0] HALF = NX_W'(32768);
  logic signed [NX_W-1:0]   ox, oy;
  logic signed [16:0]       ex0, ey0, ex1, ey1;
  logic [17:0]              sum0, sum1;
  logic                     t0, t1, hit;
  logic signed [NX_W-1:0]   fx, fy, rowv;
  logic [IDX_W-1:0]         col_n, row_n;
  logic                     o_func_r, o_zd_r, o_hit_r;
  logic [IDX_W-1:0]         o_col_r, o_row_r;
  logic [SCR_W-1:0]         o_sx_r, o_sy_r;

  always_comb begin
    ox   = p_nx_r - HALF;
    oy   = p_ny_r - HALF;
    ex0  = $signed({1'b0, p_nx_r[15:0]}) - 17'sd32768;
    ey0  = $signed({1'b0, p_ny_r[15:0]}) - 17'sd32768;
    ex1  = $signed({1'b0, ox[15:0]}) - 17'sd32768;
    ey1  = $signed({1'b0, oy[15:0]}) - 17'sd32768;
    sum0 = 18'(ex0[16] ? -ex0 : ex0) + 18'(ey0[16] ? -ey0 : ey0);
    sum1 = 18'(ex1[16] ? -ex1 : ex1) + 18'(ey1[16] ? -ey1 : ey1);
    t0   = sum0 <= 18'd32768;
    t1   = sum1 <= 18'd32768;
    hit  = !p_zd_r && (t0 || t1);
    fx   = t0 ? (p_nx_r >>> sicm_pkg::NORM_FRAC) : (ox >>> sicm_pkg::NORM_FRAC);
    fy   = t0 ? (p_ny_r >>> sicm_pkg::NORM_FRAC) : (oy >>> sicm_pkg::NORM_FRAC);
    rowv = (fy <<< 1) + NX_W'(!t0);
    col_n = hit ? sicm_pkg::sat_idx(fx) : '1;
    row_n = hit ? sicm_pkg::sat_idx(rowv) : '1;
  end

  always_ff @(posedge clk) begin
    if (en[OUT_ST]) begin
      o_func_r <= p_func_r;
      o_zd_r   <= p_zd_r;
      if (p_func_r == sicm_pkg::FUNC_PLACE) begin
        o_hit_r <= 1'b1;
        o_col_r <= '0;
        o_row_r <= '0;
        o_sx_r  <= p_sx_r;
        o_sy_r  <= p_sy_r;
      end else begin
        o_hit_r <= hit;
        o_col_r <= col_n;
        o_row_r <= row_n;
        o_sx_r  <= '0;
        o_sy_r  <= '0;
      end
    end
  end

  assign out_if.valid      = v_r[OUT_ST];
  assign out_if.hit        = o_hit_r;
  assign out_if.column_out = o_col_r;
  assign out_if.row_out    = o_row_r;
  assign out_if.screen_x   = o_sx_r;
  assign out_if.screen_y   = o_sy_r;

  // Checks
  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !o_hit_r |-> (o_col_r == '1) && (o_row_r == '1))
    else $error("miss without -1 indexes");

  a_place_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (o_func_r == sicm_pkg::FUNC_PLACE) |-> o_hit_r)
    else $error("place result without hit");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (o_func_r == sicm_pkg::FUNC_PICK) && o_zd_r |-> !o_hit_r)
    else $error("pick hit with zero divisor");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the staggered isometric pick/place converter.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int SCR_W  = sicm_pkg::SCR_W;
  localparam int IDX_W  = sicm_pkg::IDX_W;
  localparam int ADDR_W = sicm_pkg::ADDR_W;

  typedef struct {
    sicm_pkg::func_t         func;
    logic signed [SCR_W-1:0] px;
    logic signed [SCR_W-1:0] py;
    logic signed [IDX_W-1:0] col;
    logic signed [IDX_W-1:0] row;
  } req_t;

  typedef struct {
    logic                    hit;
    logic signed [IDX_W-1:0] col;
    logic signed [IDX_W-1:0] row;
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
  } res_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  sicm_in_if  in_if ();
  sicm_out_if out_if ();

  staggered_iso_coordinate_map_core u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the map registers
  longint cam_x, cam_y, zoom_r, cw_r, ch_r;

  req_t   pending_reqs[$];
  res_t   expected_res[$];
  int     errors = 0;
  int     recv_hold;
  bit     hold_done;
  bit     long_hold_go = 1'b0;
  bit     send_pause = 1'b0;
  int     idle_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && ((a < 0) != (d < 0))) q -= 1;
    return q;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Diamond test on a grid whose corners sit at integer + ofs (16 fraction bits)
  function automatic bit in_diamond(longint nx, longint ny, longint ofs,
                                    output longint cx, output longint cy);
    longint rx, ry, ax, ay;
    cx = floor_quot(nx - ofs, 65536);
    cy = floor_quot(ny - ofs, 65536);
    rx = (nx - ofs) - cx * 65536 - 32768;
    ry = (ny - ofs) - cy * 65536 - 32768;
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    return (ax + ay) <= 32768;
  endfunction

  function automatic res_t map_coord(req_t q);
    res_t   r;
    longint nx, ny, cx, cy, x2, y2, odd;
    r = '{hit: 1'b0, col: '0, row: '0, sx: '0, sy: '0};
    if (q.func == sicm_pkg::FUNC_PICK) begin
      r.col = '1;
      r.row = '1;
      if (zoom_r != 0 && cw_r != 0 && ch_r != 0) begin
        nx = floor_quot((longint'(q.px) - cam_x) * 256 * 65536, zoom_r * cw_r);
        ny = floor_quot((longint'(q.py) - cam_y) * 256 * 65536, zoom_r * ch_r);
        if (in_diamond(nx, ny, 0, cx, cy)) begin
          r.hit = 1'b1;
          r.col = IDX_W'(clamp(cx, IDX_W));
          r.row = IDX_W'(clamp(cy * 2, IDX_W));
        end else if (in_diamond(nx, ny, 32768, cx, cy)) begin
          r.hit = 1'b1;
          r.col = IDX_W'(clamp(cx, IDX_W));
          r.row = IDX_W'(clamp(cy * 2 + 1, IDX_W));
        end
      end
    end else begin
      odd = q.row[0];
      x2 = (2 * longint'(q.col) + 1 + odd) * cw_r;
      y2 = (longint'(q.row) + 1) * ch_r;
      r.hit = 1'b1;
      r.sx = SCR_W'(clamp(cam_x + floor_quot(x2 * zoom_r + 256, 512), SCR_W));
      r.sy = SCR_W'(clamp(cam_y + floor_quot(y2 * zoom_r + 256, 512), SCR_W));
    end
    return r;
  endfunction

  task automatic write_reg(sicm_pkg::reg_idx_t idx, longint val);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_paddr   <= ADDR_W'(idx) << 2;
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    @(posedge clk);
    case (idx)
      sicm_pkg::REG_CAMERA_X:    cam_x  = longint'($signed(val[SCR_W-1:0]));
      sicm_pkg::REG_CAMERA_Y:    cam_y  = longint'($signed(val[SCR_W-1:0]));
      sicm_pkg::REG_ZOOM:        zoom_r = val & 64'hFFFF;
      sicm_pkg::REG_CELL_WIDTH:  cw_r   = val & 64'h7FFFFF;
      default:                   ch_r   = val & 64'h7FFFFF;
    endcase
  endtask

  function automatic req_t rand_req();
    req_t q;
    q.func = sicm_pkg::func_t'($urandom_range(0, 1));
    q.px   = SCR_W'($urandom);
    q.py   = SCR_W'($urandom);
    q.col  = IDX_W'($urandom);
    q.row  = IDX_W'($urandom);
    // Keep most picks near the camera so hits are common
    if ($urandom_range(0, 3) != 0) begin
      q.px = SCR_W'(cam_x + $signed(24'($urandom_range(0, 20000)) - 24'sd10000));
      q.py = SCR_W'(cam_y + $signed(24'($urandom_range(0, 20000)) - 24'sd10000));
      q.col = $signed(16'($urandom_range(0, 60))) - 16'sd30;
      q.row = $signed(16'($urandom_range(0, 60))) - 16'sd30;
    end
    return q;
  endfunction

  function automatic req_t mk_req(sicm_pkg::func_t f, longint px, longint py,
                                  longint c, longint r);
    req_t q;
    q.func = f;
    q.px = SCR_W'(px);
    q.py = SCR_W'(py);
    q.col = IDX_W'(c);
    q.row = IDX_W'(r);
    return q;
  endfunction

  // Append one item to the send queue
  task automatic add_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  // Wait until every expected result has come back, then let the pipe drain
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Driver: present pending items with random gaps
  int   gap_left;
  bit   drv_acc;
  int   drv_wait;
  req_t drv_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.func      <= 1'b0;
      in_if.point_x   <= '0;
      in_if.point_y   <= '0;
      in_if.column_in <= '0;
      in_if.row_in    <= '0;
      gap_left        <= 0;
    end else begin
      drv_acc = in_if.valid && in_if.ready;
      // Log the accepted transfer for the checker
      if (drv_acc) begin
        expected_res.insert(expected_res.size(), map_coord(pending_reqs.pop_front()));
      end
      // Offer the next item once the channel is free and the gap has run out
      if (drv_acc || !in_if.valid) begin
        drv_wait = drv_acc ? int'($urandom_range(0, 4)) : gap_left;
        if (drv_wait == 0 && !send_pause && pending_reqs.size() != 0) begin
          drv_req = pending_reqs[0];
          in_if.valid     <= 1'b1;
          in_if.func      <= drv_req.func;
          in_if.point_x   <= drv_req.px;
          in_if.point_y   <= drv_req.py;
          in_if.column_in <= drv_req.col;
          in_if.row_in    <= drv_req.row;
          gap_left        <= 0;
        end else begin
          in_if.valid <= 1'b0;
          gap_left    <= (drv_wait != 0) ? drv_wait - 1 : 0;
        end
      end
    end
  end

  // Monitor: random back-pressure and result checking
  int   stall_left;
  int   mon_s;
  res_t mon_exp;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 0;
      stall_left <= 0;
      recv_hold <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result hit=%0d col=%0d row=%0d", out_if.hit,
                 out_if.column_out, out_if.row_out);
          errors++;
        end else begin
          mon_exp = expected_res.pop_front();
          if (out_if.hit !== mon_exp.hit) begin
            $error("hit exp %0d got %0d", mon_exp.hit, out_if.hit); errors++;
          end
          if (out_if.column_out !== mon_exp.col) begin
            $error("column_out exp %0d got %0d", mon_exp.col, out_if.column_out); errors++;
          end
          if (out_if.row_out !== mon_exp.row) begin
            $error("row_out exp %0d got %0d", mon_exp.row, out_if.row_out); errors++;
          end
          if (out_if.screen_x !== mon_exp.sx) begin
            $error("screen_x exp %0d got %0d", mon_exp.sx, out_if.screen_x); errors++;
          end
          if (out_if.screen_y !== mon_exp.sy) begin
            $error("screen_y exp %0d got %0d", mon_exp.sy, out_if.screen_y); errors++;
          end
        end
      end
      if (long_hold_go && !hold_done) begin
        // Start one long hold-off so the pipeline backs up
        out_if.ready <= 0;
        recv_hold <= 60;
        hold_done <= 1'b1;
      end else if (recv_hold != 0) begin
        out_if.ready <= 0;
        recv_hold <= recv_hold - 1;
      end else if (stall_left != 0) begin
        out_if.ready <= (stall_left == 1);
        stall_left <= stall_left - 1;
      end else if (out_if.valid && out_if.ready || !out_if.ready) begin
        mon_s = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 4));
        out_if.ready <= (mon_s == 0);
        stall_left <= mon_s;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("staggered_iso_coordinate_map_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    cam_x = 0; cam_y = 0; zoom_r = 256; cw_r = 16384; ch_r = 8192;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: default geometry, corners, diamond edges, extremes
    add_req(mk_req(sicm_pkg::FUNC_PICK, 0, 0, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, 8192, 4096, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, 16384, 4096, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, 12288, 4096, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, 4096, 2048, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, -1, -1, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, 8388607, 8388607, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, -8388608, -8388608, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, 3, 5));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, -1, -1));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, 32767, 32767));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, -32768, -32768));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, -1, -1, 7, -3));
    drain();

    // Tiny cells: index saturation, extreme camera and zoom
    write_reg(sicm_pkg::REG_CELL_WIDTH, 1);
    write_reg(sicm_pkg::REG_CELL_HEIGHT, 1);
    write_reg(sicm_pkg::REG_ZOOM, 1);
    write_reg(sicm_pkg::REG_CAMERA_X, -8388608);
    write_reg(sicm_pkg::REG_CAMERA_Y, 8388607);
    add_req(mk_req(sicm_pkg::FUNC_PICK, 8388607, -8388608, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PICK, -8388608, 8388607, 0, 0));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, 32767, -32768));
    drain();
    write_reg(sicm_pkg::REG_ZOOM, 65535);
    write_reg(sicm_pkg::REG_CELL_WIDTH, 8388607);
    write_reg(sicm_pkg::REG_CELL_HEIGHT, 8388607);
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, 32767, 32767));
    add_req(mk_req(sicm_pkg::FUNC_PLACE, 0, 0, -32768, -32768));
    add_req(mk_req(sicm_pkg::FUNC_PICK, 8388607, -8388608, 0, 0));
    drain();
    // Zero divisor gives a miss
    write_reg(sicm_pkg::REG_ZOOM, 0);
    add_req(mk_req(sicm_pkg::FUNC_PICK, 100, 100, 0, 0));
    drain();
    write_reg(sicm_pkg::REG_ZOOM, 256);
    write_reg(sicm_pkg::REG_CELL_WIDTH, 0);
    add_req(mk_req(sicm_pkg::FUNC_PICK, 100, 100, 0, 0));
    drain();
    write_reg(sicm_pkg::REG_CELL_WIDTH, 4096);
    write_reg(sicm_pkg::REG_CELL_HEIGHT, 0);
    add_req(mk_req(sicm_pkg::FUNC_PICK, 100, 100, 0, 0));
    drain();

    // Random phases under several geometries
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sicm_pkg::REG_CAMERA_X, $signed(24'($urandom)));
      write_reg(sicm_pkg::REG_CAMERA_Y, $signed(24'($urandom)));
      write_reg(sicm_pkg::REG_ZOOM, $urandom_range(1, 1024));
      write_reg(sicm_pkg::REG_CELL_WIDTH, $urandom_range(256, 16384));
      write_reg(sicm_pkg::REG_CELL_HEIGHT, $urandom_range(128, 8192));
      if (ph == 5) begin
        write_reg(sicm_pkg::REG_ZOOM, $urandom_range(1, 65535));
        write_reg(sicm_pkg::REG_CELL_WIDTH, $urandom_range(1, 8388607));
      end
      for (int i = 0; i < 100; i++) add_req(rand_req());
      // Hold off the receiver long enough to back up the pipeline
      if (ph == 2) long_hold_go <= 1'b1;
      drain();
    end

    // Sender pauses mid-burst until every result is home, then finishes
    for (int i = 0; i < 20; i++) add_req(rand_req());
    while (pending_reqs.size() > 10) @(posedge clk);
    send_pause <= 1'b1;
    @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    send_pause <= 1'b0;
    drain();

    if (errors == 0) begin
      $display("staggered_iso_coordinate_map_core verification clean");
    end else begin
      $display("staggered_iso_coordinate_map_core verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
